### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is held low.
`define SMD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked during reset too.
`define SMD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/smd_pkg.sv
// Types and constants of the SHA-1 digest unit.
// No dependencies.
`default_nettype none

package smd_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned NUM_CHAIN = 5;
    localparam int unsigned NUM_BLOCK_WORDS = 16;
    localparam int unsigned NUM_ROUNDS = 80;

    localparam t_word INIT_WORDS [NUM_CHAIN] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam t_word K_0 = 32'h5A827999;
    localparam t_word K_1 = 32'h6ED9EBA1;
    localparam t_word K_2 = 32'h8F1BBCDC;
    localparam t_word K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    function automatic t_word rotl(input t_word v, input int unsigned n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

endpackage

`default_nettype wire

### rtl/core/sha1_message_digest_unit.sv
// SHA-1 message digest unit: byte input, padding, 80-round compression, digest output.
// Depends on smd_pkg and assert_macros.svh.
//
// Message bytes enter one per input transaction and are shifted into a 16-word block
// register. A byte that neither completes a block nor closes the message leaves the
// input free for the next transaction. A byte that completes a 64-byte block holds the
// input stalled through the 80 rounds in the single round adder and the chaining add.
// A closing transaction adds the padding at one byte per cycle while no compression
// runs, with one or two further compressions, then offers the five digest words on
// five output transactions, most significant first. After the fifth word the unit
// returns to its initial state.
`default_nettype none

`include "assert_macros.svh"

module sha1_message_digest_unit
    import smd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_last_item,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [60:0] r_total, n_total;
    logic [6:0]  r_round, n_round;
    logic [2:0]  r_out_idx, n_out_idx;
    logic        r_pend_last, n_pend_last;
    logic        r_pad_first, n_pad_first;
    logic        r_in_len, n_in_len;
    t_word       r_chain [NUM_CHAIN];
    t_word       n_chain [NUM_CHAIN];
    t_word       r_w [NUM_BLOCK_WORDS];
    t_word       n_w [NUM_BLOCK_WORDS];
    t_word       r_a, r_b, r_c, r_d, r_e;
    t_word       n_a, n_b, n_c, n_d, n_e;

    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_push;
    logic [7:0]  w_push_byte;
    logic [63:0] w_len_bits;
    logic [7:0]  w_len_byte;
    t_word       w_f, w_k, w_t, w_sched;

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = r_chain[r_out_idx];
    assign o_word_index  = r_out_idx;
    assign o_last_word   = (r_out_idx == 3'd4);

    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;

    assign w_len_bits = {r_total, 3'b000};
    assign w_len_byte = w_len_bits[{~r_fill[2:0], 3'b000} +: 8];

    always_comb begin
        if (r_round < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = K_0;
        end else if (r_round < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_1;
        end else if (r_round < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = K_2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_3;
        end
        w_t = rotl(r_a, 5) + w_f + r_e + w_k + r_w[0];
        w_sched = rotl(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0], 1);
    end

    always_comb begin
        w_push      = 1'b0;
        w_push_byte = i_data_byte;
        n_state     = r_state;
        n_fill      = r_fill;
        n_total     = r_total;
        n_round     = r_round;
        n_out_idx   = r_out_idx;
        n_pend_last = r_pend_last;
        n_pad_first = r_pad_first;
        n_in_len    = r_in_len;
        n_chain     = r_chain;
        n_w         = r_w;
        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d; n_e = r_e;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_pend_last = i_last_item;
                    n_pad_first = i_last_item;
                    if (i_has_byte) begin
                        w_push  = 1'b1;
                        n_total = r_total + 61'd1;
                    end
                    if (i_last_item) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                w_push = 1'b1;
                if (r_pad_first) begin
                    w_push_byte = PAD_MARK;
                    n_pad_first = 1'b0;
                end else if (r_in_len || r_fill == LEN_OFFSET) begin
                    w_push_byte = w_len_byte;
                    n_in_len    = 1'b1;
                end else begin
                    w_push_byte = 8'h00;
                end
            end
            S_ROUND: begin
                n_e = r_d;
                n_d = r_c;
                n_c = rotl(r_b, 30);
                n_b = r_a;
                n_a = w_t;
                for (int j = 0; j < NUM_BLOCK_WORDS - 1; j++) begin
                    n_w[j] = r_w[j + 1];
                end
                n_w[NUM_BLOCK_WORDS - 1] = w_sched;
                n_round = r_round + 7'd1;
                if (r_round == 7'(NUM_ROUNDS - 1)) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_chain[0] = r_chain[0] + r_a;
                n_chain[1] = r_chain[1] + r_b;
                n_chain[2] = r_chain[2] + r_c;
                n_chain[3] = r_chain[3] + r_d;
                n_chain[4] = r_chain[4] + r_e;
                if (r_in_len) begin
                    n_state   = S_OUT;
                    n_out_idx = 3'd0;
                end else if (r_pend_last) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (w_out_acc) begin
                    if (o_last_word) begin
                        n_state     = S_IDLE;
                        n_out_idx   = 3'd0;
                        n_fill      = 6'd0;
                        n_total     = '0;
                        n_pend_last = 1'b0;
                        n_pad_first = 1'b0;
                        n_in_len    = 1'b0;
                        n_chain     = INIT_WORDS;
                    end else begin
                        n_out_idx = r_out_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_push) begin
            for (int j = 0; j < NUM_BLOCK_WORDS - 1; j++) begin
                n_w[j] = {r_w[j][23:0], r_w[j + 1][31:24]};
            end
            n_w[NUM_BLOCK_WORDS - 1] = {r_w[NUM_BLOCK_WORDS - 1][23:0], w_push_byte};
            n_fill = r_fill + 6'd1;
            if (r_fill == 6'd63) begin
                n_state = S_ROUND;
                n_round = 7'd0;
                n_a = r_chain[0]; n_b = r_chain[1]; n_c = r_chain[2];
                n_d = r_chain[3]; n_e = r_chain[4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= 6'd0;
            r_total     <= '0;
            r_round     <= 7'd0;
            r_out_idx   <= 3'd0;
            r_pend_last <= 1'b0;
            r_pad_first <= 1'b0;
            r_in_len    <= 1'b0;
            r_chain     <= INIT_WORDS;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_total     <= n_total;
            r_round     <= n_round;
            r_out_idx   <= n_out_idx;
            r_pend_last <= n_pend_last;
            r_pad_first <= n_pad_first;
            r_in_len    <= n_in_len;
            r_chain     <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        r_a <= n_a;
        r_b <= n_b;
        r_c <= n_c;
        r_d <= n_d;
        r_e <= n_e;
    end

    `SMD_ASSERT(a_block_empty_at_add, i_clk, i_rst_n,
        (r_state == S_ADD) |-> (r_fill == 6'd0), "block not empty at chaining add")
    `SMD_ASSERT(a_out_after_add, i_clk, i_rst_n,
        (r_state == S_OUT && $past(r_state) != S_OUT) |-> ($past(r_state) == S_ADD),
        "digest offered without a final add")
    `SMD_ASSERT(a_word_step, i_clk, i_rst_n,
        (w_out_acc && !o_last_word) |=> (o_valid && o_word_index == $past(o_word_index) + 3'd1),
        "digest word index skipped")
    `SMD_ASSERT(a_clear_after_digest, i_clk, i_rst_n,
        (w_out_acc && o_last_word) |=> (r_state == S_IDLE && r_fill == 6'd0 && r_total == 61'd0),
        "state not cleared after digest")

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for sha1_message_digest_unit: byte transactions in, digest words out.
// Holds its own SHA-1 predictor and checks every digest word in order.
// Depends on smd_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module testbench
    import smd_pkg::*;
();

    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned TAIL_CYCLES = 300;
    localparam int unsigned PHASE_ITEMS = 40;

    typedef struct {
        logic [7:0] data;
        logic       has;
        logic       last;
    } t_byte_item;

    typedef struct {
        t_word      word;
        logic [2:0] index;
        logic       last;
    } t_digest_word;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_has_byte = 1'b0;
    logic        i_last_item = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    t_byte_item   byte_items [$];
    t_digest_word digest_words_due [$];

    t_word       hash_chain [NUM_CHAIN];
    logic [7:0]  hash_block [64];
    logic [6:0]  hash_fill;
    logic [60:0] hash_len;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_len = 0;
    logic        rx_holding = 1'b0;
    logic        in_fire = 1'b0;
    int unsigned quiet_cycles = 0;
    int unsigned errors = 0;
    event        hold_go;

    sha1_message_digest_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_has_byte    (i_has_byte),
        .i_last_item   (i_last_item),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_word rol32(input t_word v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic clear_hash();
        int i;
        for (i = 0; i < NUM_CHAIN; i++) hash_chain[i] = INIT_WORDS[i];
        for (i = 0; i < 64; i++) hash_block[i] = 8'h00;
        hash_fill = '0;
        hash_len = '0;
    endtask

    task automatic compress_block();
        t_word w [NUM_ROUNDS];
        t_word a, b, c, d, e, f, k, t;
        int i;
        for (i = 0; i < NUM_BLOCK_WORDS; i++)
            w[i] = {hash_block[4*i], hash_block[4*i+1], hash_block[4*i+2], hash_block[4*i+3]};
        for (i = NUM_BLOCK_WORDS; i < NUM_ROUNDS; i++)
            w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2];
        d = hash_chain[3]; e = hash_chain[4];
        for (i = 0; i < NUM_ROUNDS; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = K_0;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = K_1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = K_2;
            end else begin
                f = b ^ c ^ d; k = K_3;
            end
            t = rol32(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol32(b, 30); b = a; a = t;
        end
        hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c;
        hash_chain[3] += d; hash_chain[4] += e;
    endtask

    task automatic absorb_byte(input logic [7:0] v);
        hash_block[hash_fill[5:0]] = v;
        hash_fill = hash_fill + 7'd1;
        if (hash_fill >= 7'd64) begin
            compress_block();
            hash_fill = '0;
        end
    endtask

    task automatic hash_item(input logic [7:0] data, input logic has, input logic last);
        logic [63:0]  bit_len;
        t_digest_word rec;
        int i;
        if (has) begin
            hash_len = hash_len + 61'd1;
            absorb_byte(data);
        end
        if (last) begin
            bit_len = {hash_len, 3'b000};
            absorb_byte(PAD_MARK);
            while (hash_fill != {1'b0, LEN_OFFSET}) absorb_byte(8'h00);
            for (i = 0; i < 8; i++) absorb_byte(bit_len[63 - 8*i -: 8]);
            for (i = 0; i < NUM_CHAIN; i++) begin
                rec.word = hash_chain[i];
                rec.index = i[2:0];
                rec.last = (i == NUM_CHAIN - 1);
                digest_words_due = {digest_words_due, rec};
            end
            clear_hash();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (errors < 200)
            $display("mismatch %s: expected %h got %h at %0t", what, want, got, $time);
        errors++;
    endtask

    task automatic check_digest_word();
        t_digest_word due;
        if (digest_words_due.size() == 0) begin
            report_mismatch("unexpected digest word", 32'h0, o_digest_word);
            return;
        end
        due = digest_words_due.pop_front();
        if (o_digest_word !== due.word) report_mismatch("digest_word", due.word, o_digest_word);
        if (o_word_index !== due.index)
            report_mismatch("word_index", {29'd0, due.index}, {29'd0, o_word_index});
        if (o_last_word !== due.last)
            report_mismatch("last_word", {31'd0, due.last}, {31'd0, o_last_word});
    endtask

    always @(posedge i_clk) begin
        in_fire = i_rst_n && i_valid && !o_stall;
        if (in_fire) hash_item(i_data_byte, i_has_byte, i_last_item);
        if (i_rst_n && o_valid && !i_stall) check_digest_word();
    end

    always @(negedge i_clk) begin
        t_byte_item cur;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_fire) begin
            if (byte_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                cur = byte_items.pop_front();
                i_valid <= 1'b1;
                i_data_byte <= cur.data;
                i_has_byte <= cur.has;
                i_last_item <= cur.last;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= rx_holding || ($urandom_range(0, 99) < recv_stall_pct);
    end

    always begin
        @(hold_go);
        rx_holding = 1'b1;
        repeat (hold_len) @(posedge i_clk);
        rx_holding = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", quiet_cycles);
            $display("** sha1_message_digest_unit: FAILED **");
            $finish;
        end
    end

    task automatic queue_item(input logic [7:0] data, input logic has, input logic last);
        t_byte_item it;
        it.data = data;
        it.has = has;
        it.last = last;
        byte_items = {byte_items, it};
    endtask

    task automatic queue_message(input int unsigned len, input logic close_empty,
                                 inout int unsigned counted);
        int unsigned i;
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            queue_item(8'($urandom_range(0, 255)), 1'b1, !close_empty && (i == len - 1));
            counted++;
        end
        if (close_empty) begin
            queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            counted++;
        end
    endtask

    task automatic queue_random_message(inout int unsigned counted);
        int unsigned pick, len;
        logic close_empty;
        pick = $urandom_range(0, 19);
        if (pick < 12) len = $urandom_range(0, 12);
        else if (pick < 16) len = $urandom_range(53, 57);
        else if (pick < 19) len = $urandom_range(62, 66);
        else len = $urandom_range(118, 121);
        close_empty = (len == 0) || ($urandom_range(0, 1) == 1);
        queue_message(len, close_empty, counted);
    endtask

    task automatic drain();
        while (byte_items.size() != 0 || i_valid || digest_words_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
        int unsigned counted;
        counted = 0;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        while (counted < PHASE_ITEMS) queue_random_message(counted);
        drain();
    endtask

    initial begin
        int unsigned spare;
        spare = 0;
        clear_hash();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message, then a stray byte-less item
        queue_item(8'hFF, 1'b0, 1'b1);
        queue_item(8'hFF, 1'b0, 1'b0);
        // "abc" closed on its final byte
        queue_item(8'h61, 1'b1, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0);
        queue_item(8'h63, 1'b1, 1'b1);
        // extreme bytes closed by an empty item
        queue_item(8'h00, 1'b1, 1'b0);
        queue_item(8'hFF, 1'b1, 1'b0);
        queue_item(8'h00, 1'b0, 1'b0);
        queue_item(8'h00, 1'b0, 1'b1);
        // one-byte messages at both extremes and at the pad mark value
        queue_item(8'hFF, 1'b1, 1'b1);
        queue_item(8'h00, 1'b1, 1'b1);
        queue_item(8'h80, 1'b1, 1'b1);
        drain();

        run_phase(0, 0);
        run_phase(84, 0);
        run_phase(0, 84);
        run_phase(22, 22);

        // hold the output back while the input keeps offering transactions
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_len = 800;
        -> hold_go;
        queue_message(70, 1'b0, spare);
        queue_message(20, 1'b1, spare);
        queue_message(5, 1'b0, spare);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && digest_words_due.size() == 0) begin
            $display("** sha1_message_digest_unit: PASSED **");
        end else begin
            $display("** sha1_message_digest_unit: FAILED **");
        end
        $finish;
    end

endmodule
